FILE: design/ffd_pkg.sv
// Shared types, codes and helper functions for the form field extract/decode block.
// Used by ffd_step, ffd_out_queue and form_field_extract_decode_core; no dependencies.
`default_nettype none

package ffd_pkg;

  localparam int KEY_MAX_BYTES = 16;
  localparam int MAX_RESULTS   = 3;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [1:0] CFG_KEY_LENGTH     = 2'd0;
  localparam logic [1:0] CFG_KEY_BYTES_LOW  = 2'd1;
  localparam logic [1:0] CFG_KEY_BYTES_HIGH = 2'd2;
  localparam logic [1:0] CFG_VALUE_CAPACITY = 2'd3;

  localparam logic [7:0] CH_EOB     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;

  typedef enum logic [1:0] {
    PH_MATCH,
    PH_VALUE,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_PCT,
    PEND_DIGIT
  } pend_t;

  typedef struct packed {
    phase_t     phase;
    pend_t      pend;
    logic [7:0] pend_hex;
    logic [7:0] emitted;
    logic       key_found;
  } scan_t;

  localparam scan_t SCAN_RESET = '{
    phase:     PH_MATCH,
    pend:      PEND_NONE,
    pend_hex:  8'd0,
    emitted:   8'd0,
    key_found: 1'b0
  };

  typedef struct packed {
    logic [4:0]   key_length;
    logic [127:0] key_bytes;
    logic [7:0]   value_capacity;
  } cfg_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       is_char;
    logic       found;
    logic [7:0] value_length;
    logic       last;
  } result_t;

  function automatic logic hex_ok(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/ffd_step.sv
// Next-state and result logic for one body byte: key match, percent decode, status.
// Depends on ffd_pkg.
`default_nettype none

module ffd_step import ffd_pkg::*; #(
  parameter int KeyMaxBytes = KEY_MAX_BYTES
) (
  input  logic [7:0]               body_char,
  input  cfg_t                     cfg,
  input  scan_t                    scan,
  input  logic [KeyMaxBytes:0]     cand,
  output scan_t                    scan_nxt,
  output logic [KeyMaxBytes:0]     cand_nxt,
  output result_t [MAX_RESULTS-1:0] res,
  output logic [1:0]               res_cnt
);

  always_comb begin
    logic [2:0][7:0]      att;
    logic [1:0]           n_att;
    logic                 alive;
    logic [7:0]           cnt;
    logic [1:0]           rc;
    logic                 hit;
    logic [KeyMaxBytes:0] nxt;
    logic [4:0]           kl;
    logic [4:0]           eff;
    logic                 eob;
    logic                 c_hex;

    scan_nxt = scan;
    cand_nxt = cand;
    res      = '0;
    att      = '0;
    n_att    = 2'd0;
    rc       = 2'd0;
    hit      = 1'b0;
    nxt      = '0;
    eob      = (body_char == CH_EOB);
    c_hex    = hex_ok(body_char);

    // effective key length: clamp to the key store, then to the capacity
    kl  = (cfg.key_length > 5'(KeyMaxBytes)) ? 5'(KeyMaxBytes) : cfg.key_length;
    eff = ({3'b000, kl} > cfg.value_capacity) ? cfg.value_capacity[4:0] : kl;

    // collect the value bytes to try, in order
    if (scan.phase == PH_VALUE) begin
      if (eob) begin
        if (scan.pend == PEND_PCT || scan.pend == PEND_DIGIT) begin
          att[n_att] = CH_PERCENT;
          n_att      = n_att + 2'd1;
        end
        if (scan.pend == PEND_DIGIT) begin
          att[n_att] = scan.pend_hex;
          n_att      = n_att + 2'd1;
        end
      end else if (scan.pend == PEND_PCT && c_hex) begin
        scan_nxt.pend     = PEND_DIGIT;
        scan_nxt.pend_hex = body_char;
      end else if (scan.pend == PEND_DIGIT && c_hex) begin
        scan_nxt.pend = PEND_NONE;
        att[0]        = {hex_nibble(scan.pend_hex), hex_nibble(body_char)};
        n_att         = 2'd1;
      end else begin
        // flush a held escape literally, then take this byte as plain
        scan_nxt.pend = PEND_NONE;
        if (scan.pend == PEND_PCT || scan.pend == PEND_DIGIT) begin
          att[n_att] = CH_PERCENT;
          n_att      = n_att + 2'd1;
        end
        if (scan.pend == PEND_DIGIT) begin
          att[n_att] = scan.pend_hex;
          n_att      = n_att + 2'd1;
        end
        if (body_char == CH_AMP) begin
          scan_nxt.phase = PH_DONE;
        end else if (body_char == CH_PERCENT) begin
          scan_nxt.pend = PEND_PCT;
        end else if (body_char == CH_PLUS) begin
          att[n_att] = CH_SPACE;
          n_att      = n_att + 2'd1;
        end else begin
          att[n_att] = body_char;
          n_att      = n_att + 2'd1;
        end
      end
    end

    // emit while the buffer has room; the first refusal ends the value
    alive = (scan.phase == PH_VALUE);
    cnt   = scan.emitted;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (2'(k) < n_att && alive) begin
        if ({1'b0, cnt} + 9'd1 < {1'b0, cfg.value_capacity}) begin
          res[rc] = '{value_byte: att[k], is_char: 1'b1, found: 1'b0,
                      value_length: 8'd0, last: 1'b0};
          rc      = rc + 2'd1;
          cnt     = cnt + 8'd1;
        end else begin
          alive = 1'b0;
        end
      end
    end

    if (scan.phase == PH_VALUE) begin
      scan_nxt.emitted = cnt;
      if (!alive) begin
        scan_nxt.phase = PH_DONE;
        scan_nxt.pend  = PEND_NONE;
      end
    end

    if (eob) begin
      res[rc]  = '{value_byte: 8'd0, is_char: 1'b0, found: scan.key_found,
                   value_length: cnt, last: 1'b0};
      rc       = rc + 2'd1;
      scan_nxt = SCAN_RESET;
      cand_nxt = {{KeyMaxBytes{1'b0}}, 1'b1};
    end else if (scan.phase == PH_MATCH) begin
      for (int i = 0; i <= KeyMaxBytes; i++) begin
        if (cand[i] && 5'(i) == eff && body_char == CH_EQUAL &&
            cfg.value_capacity != 8'd0) begin
          hit = 1'b1;
        end
        if (i < KeyMaxBytes) begin
          if (cand[i] && 5'(i) < eff && body_char == cfg.key_bytes[8*i +: 8]) begin
            nxt[i+1] = 1'b1;
          end
        end
      end
      nxt[0] = (body_char == CH_AMP);
      if (hit) begin
        scan_nxt.phase     = PH_VALUE;
        scan_nxt.key_found = 1'b1;
        scan_nxt.emitted   = 8'd0;
        scan_nxt.pend      = PEND_NONE;
        cand_nxt           = '0;
      end else begin
        cand_nxt = nxt;
      end
    end

    if (rc != 2'd0) begin
      res[rc - 2'd1].last = 1'b1;
    end
    res_cnt = rc;
  end

endmodule

`default_nettype wire

FILE: design/ffd_out_queue.sv
// Small result queue: takes up to three words per cycle, hands out one per cycle while rd_ready is high.
// Depends on ffd_pkg.
`default_nettype none

module ffd_out_queue import ffd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  result_t [MAX_RESULTS-1:0] wr_data,
  input  logic [1:0]                wr_cnt,
  output logic                      space_ok,
  output result_t                   rd_data,
  output logic                      rd_valid,
  input  logic                      rd_ready
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  result_t         q_r [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            pop;

  assign rd_valid = (count_r != '0);
  assign rd_data  = q_r[rd_ptr_r];
  assign pop      = rd_valid && rd_ready;
  // room for a full burst, judged on the registered level only
  assign space_ok = (count_r <= CntW'(QUEUE_DEPTH - MAX_RESULTS));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PtrW'(wr_cnt);
    rd_ptr_nxt = rd_ptr_r + PtrW'(pop);
    count_nxt  = count_r + CntW'(wr_cnt) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (2'(k) < wr_cnt) begin
        q_r[wr_ptr_r + PtrW'(k)] <= wr_data[k];
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/form_field_extract_decode_core.sv
// Top level of the form field extract/decode block: config registers, scan state,
// step logic and result queue. Depends on ffd_pkg, ffd_step and ffd_out_queue.
`default_nettype none

// Channel  Dir  Ports                          Word contents (low bit first)
// in_      in   tvalid/tready/tdata[7:0]       body_char
// out_     out  tvalid/tready/tdata[23:0]      value_byte, found, value_length, zero pad
//               tuser, tlast                   tuser = is_char, tlast = last
// cfg_     in   wr_en/addr[1:0]/wdata[63:0]    key_length, key_bytes_low/high, capacity
//
// Each accepted body byte is decoded in the cycle it is taken; its zero to three
// result words land in a four-entry queue and leave on out_ in order, one a cycle while out_tready is high.
// in_tready is high while the registered queue level is at most one word: with the
// reader always ready, a byte yielding two or three words holds off the next byte.
// A byte 0 that ends the body yields the status word and clears the scan state.
// rst_n is synchronous: config returns to its defaults, scan state and queue clear.

module form_field_extract_decode_core import ffd_pkg::*; #(
  parameter int KeyMaxBytes = KEY_MAX_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] body_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,    // [7:0] value_byte, [8] found, [16:9] value_length
  output logic        out_tuser,    // [0] is_char
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [63:0] cfg_wdata
);

  cfg_t                      cfg_r;
  scan_t                     scan_r, scan_nxt;
  logic [KeyMaxBytes:0]      cand_r, cand_nxt;
  result_t [MAX_RESULTS-1:0] step_res;
  logic [1:0]                step_cnt;
  logic                      in_fire;
  logic                      space_ok;
  result_t                   head;

  assign in_tready = space_ok;
  assign in_fire   = in_tvalid && in_tready;

  // Config writes: take the addressed register as is; no read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_length     <= 5'd4;
      cfg_r.key_bytes      <= '0;
      cfg_r.value_capacity <= 8'd64;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_KEY_LENGTH:     cfg_r.key_length        <= cfg_wdata[4:0];
        CFG_KEY_BYTES_LOW:  cfg_r.key_bytes[63:0]   <= cfg_wdata;
        CFG_KEY_BYTES_HIGH: cfg_r.key_bytes[127:64] <= cfg_wdata;
        CFG_VALUE_CAPACITY: cfg_r.value_capacity    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  ffd_step #(
    .KeyMaxBytes (KeyMaxBytes)
  ) u_step (
    .body_char (in_tdata),
    .cfg       (cfg_r),
    .scan      (scan_r),
    .cand      (cand_r),
    .scan_nxt  (scan_nxt),
    .cand_nxt  (cand_nxt),
    .res       (step_res),
    .res_cnt   (step_cnt)
  );

  // Advance the scan state only on an accepted byte; hold otherwise.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= SCAN_RESET;
      cand_r <= {{KeyMaxBytes{1'b0}}, 1'b1};
    end else if (in_fire) begin
      scan_r <= scan_nxt;
      cand_r <= cand_nxt;
    end
  end

  ffd_out_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_data  (step_res),
    .wr_cnt   (in_fire ? step_cnt : 2'd0),
    .space_ok (space_ok),
    .rd_data  (head),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready)
  );

  assign out_tdata = {7'd0, head.value_length, head.found, head.value_byte};
  assign out_tuser = head.is_char;
  assign out_tlast = head.last;

`ifndef SYNTHESIS
  // Once a key has matched, no field-start candidate survives until end of body.
  a_cand_clear: assert property (@(posedge clk) disable iff (!rst_n)
    scan_r.phase != PH_MATCH |-> cand_r == '0)
    else $error("match candidates live outside the match phase");

  // Being inside a value implies the key was found.
  a_value_found: assert property (@(posedge clk) disable iff (!rst_n)
    scan_r.phase == PH_VALUE |-> scan_r.key_found)
    else $error("value phase without a found key");

  // A held escape only exists while a value is being emitted.
  a_pend_phase: assert property (@(posedge clk) disable iff (!rst_n)
    scan_r.pend != PEND_NONE |-> scan_r.phase == PH_VALUE)
    else $error("held escape outside the value phase");

  // End of body returns the scan to its starting point.
  a_eob_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tdata == CH_EOB |=>
      scan_r.phase == PH_MATCH && scan_r.emitted == 8'd0 && !scan_r.key_found &&
      cand_r == {{KeyMaxBytes{1'b0}}, 1'b1})
    else $error("scan state not cleared after end of body");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_form_field_extract_decode_core.sv
// Self-checking bench for form_field_extract_decode_core: streams form bodies in, predicts
// every value and status word, and checks the result stream word by word.
// Depends on ffd_pkg and the core itself; needs no files or arguments.
`timescale 1ns / 1ps

module tb_form_field_extract_decode_core;
  import ffd_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_BYTES  = 40;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       is_char;
    logic       found;
    logic [7:0] value_length;
    logic       last;
  } value_word_t;

  // DUT ports; every input starts at a known value
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_addr = CFG_KEY_LENGTH;
  logic [63:0] cfg_wdata = 64'd0;

  // Register copies as the core holds them
  logic [4:0]   key_len_cfg;
  logic [127:0] key_cfg;
  logic [7:0]   cap_cfg;

  // Scan state of the prediction
  phase_t                  scan_ph;
  logic [KEY_MAX_BYTES:0]  name_hits;   // bit i: a field start has matched i key bytes
  pend_t                   held;
  logic [7:0]              held_digit;
  logic [7:0]              out_count;
  logic                    have_field;

  value_word_t word_burst [MAX_RESULTS];
  int          burst_len;

  logic [7:0]  body_q[$];       // body bytes waiting for the driver
  value_word_t expect_q[$];     // words the core still owes us
  value_word_t want_word;

  int  bytes_queued;
  int  send_mode = 1;
  int  recv_mode = 1;
  int  send_wait = 0;
  int  recv_wait = 0;
  int  words_seen = 0;
  int  error_count = 0;
  int  cycle_count = 0;
  bit  stall_go = 1'b0;
  logic hold_off = 1'b0;

  form_field_extract_decode_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------

  function automatic bit is_hex_char(logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  // '0'..'9' carry their value in the low nibble; 'A'/'a' start at nibble 1
  function automatic logic [3:0] hex_digit_value(logic [7:0] c);
    if (c <= 8'h39) begin
      return c[3:0];
    end
    return c[3:0] + 4'd9;
  endfunction

  // Name length that actually takes part: capped by the key store and by capacity
  function automatic int eff_key_len();
    int k;
    k = (key_len_cfg > KEY_MAX_BYTES) ? KEY_MAX_BYTES : int'(key_len_cfg);
    return (k > int'(cap_cfg)) ? int'(cap_cfg) : k;
  endfunction

  function automatic void clear_scan();
    scan_ph    = PH_MATCH;
    name_hits  = 1;
    held       = PEND_NONE;
    held_digit = 8'd0;
    out_count  = 8'd0;
    have_field = 1'b0;
  endfunction

  function automatic void queue_word(logic [7:0] b, logic ch, logic f, logic [7:0] n);
    if (burst_len < MAX_RESULTS) begin
      word_burst[burst_len] = '{value_byte: b, is_char: ch, found: f, value_length: n,
                                last: 1'b0};
      burst_len++;
    end
  endfunction

  // A byte that would go past capacity-1 closes the value for the rest of the body
  function automatic void emit_value_byte(logic [7:0] c);
    if (scan_ph != PH_VALUE) begin
      return;
    end
    if (int'(out_count) + 1 < int'(cap_cfg)) begin
      queue_word(c, 1'b1, 1'b0, 8'd0);
      out_count++;
    end else begin
      scan_ph = PH_DONE;
      held    = PEND_NONE;
    end
  endfunction

  function automatic void take_plain(logic [7:0] c);
    if (scan_ph != PH_VALUE) begin
      return;
    end
    if (c == CH_AMP) begin
      scan_ph = PH_DONE;
    end else if (c == CH_PLUS) begin
      emit_value_byte(CH_SPACE);
    end else if (c == CH_PERCENT) begin
      held = PEND_PCT;
    end else begin
      emit_value_byte(c);
    end
  endfunction

  // Broken escape: pass the held '%' and digit through as they came
  function automatic void release_held();
    pend_t was;
    was  = held;
    held = PEND_NONE;
    if (was != PEND_NONE) begin
      emit_value_byte(CH_PERCENT);
    end
    if (was == PEND_DIGIT) begin
      emit_value_byte(held_digit);
    end
  endfunction

  function automatic void take_value(logic [7:0] c);
    case (held)
      PEND_PCT: begin
        if (is_hex_char(c)) begin
          held_digit = c;
          held       = PEND_DIGIT;
          return;
        end
        release_held();
        take_plain(c);
      end
      PEND_DIGIT: begin
        if (is_hex_char(c)) begin
          held = PEND_NONE;
          emit_value_byte({hex_digit_value(held_digit), hex_digit_value(c)});
          return;
        end
        release_held();
        take_plain(c);
      end
      default: take_plain(c);
    endcase
  endfunction

  // Track every field start in flight; the earliest one that completes wins
  function automatic void take_name(logic [7:0] c);
    int klen;
    logic [KEY_MAX_BYTES:0] nxt;
    klen = eff_key_len();
    nxt  = '0;
    for (int i = 0; i <= klen; i++) begin
      if (!name_hits[i]) begin
        continue;
      end
      if (i < klen) begin
        if (c == key_cfg[8*i +: 8]) begin
          nxt[i+1] = 1'b1;
        end
      end else if (c == CH_EQUAL && cap_cfg != 8'd0) begin
        scan_ph    = PH_VALUE;
        have_field = 1'b1;
        out_count  = 8'd0;
        held       = PEND_NONE;
        name_hits  = '0;
        return;
      end
    end
    if (c == CH_AMP) begin
      nxt[0] = 1'b1;
    end
    name_hits = nxt;
  endfunction

  function automatic void predict_body_byte(logic [7:0] c);
    burst_len = 0;
    if (c == CH_EOB) begin
      if (scan_ph == PH_VALUE) begin
        release_held();
      end
      queue_word(8'd0, 1'b0, have_field, out_count);
      clear_scan();
    end else if (scan_ph == PH_MATCH) begin
      take_name(c);
    end else if (scan_ph == PH_VALUE) begin
      take_value(c);
    end
    if (burst_len > 0) begin
      word_burst[burst_len-1].last = 1'b1;
    end
    for (int i = 0; i < burst_len; i++) begin
      expect_q.push_back(word_burst[i]);
    end
  endfunction

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  // Mode 0: no idling, 1: full 0..17 range, 2: mostly back to back with rare gaps
  function automatic int draw_gap(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 17);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
    endcase
  endfunction

  // Small alphabet so random names collide with the key; separators make overlaps
  function automatic logic [7:0] name_char();
    case ($urandom_range(0, 11))
      0: return CH_AMP;
      1: return CH_EQUAL;
      2: return CH_PLUS;
      3: return CH_PERCENT;
      default: return 8'h61 + 8'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [63:0] alphabet_key();
    logic [63:0] k;
    for (int i = 0; i < 8; i++) begin
      k[8*i +: 8] = name_char();
    end
    return k;
  endfunction

  function automatic logic [7:0] hex_char();
    case ($urandom_range(0, 2))
      0: return 8'h30 + 8'($urandom_range(0, 9));
      1: return 8'h41 + 8'($urandom_range(0, 5));
      default: return 8'h61 + 8'($urandom_range(0, 5));
    endcase
  endfunction

  function automatic logic [7:0] non_hex_char();
    case ($urandom_range(0, 5))
      0: return CH_AMP;
      1: return CH_PLUS;
      2: return CH_PERCENT;
      default: return 8'h67 + 8'($urandom_range(0, 19));
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b);
    body_q.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i]);
    end
  endtask

  task automatic push_value_piece();
    case ($urandom_range(0, 9))
      4: push_byte(CH_PLUS);
      5, 6: begin
        push_byte(CH_PERCENT);
        push_byte(hex_char());
        push_byte(hex_char());
      end
      7: begin
        push_byte(CH_PERCENT);
        push_byte(hex_char());
        push_byte(non_hex_char());
      end
      8: begin
        push_byte(CH_PERCENT);
        push_byte(non_hex_char());
      end
      9: push_byte(8'($urandom_range(1, 255)));
      default: push_byte(8'h61 + 8'($urandom_range(0, 25)));
    endcase
  endtask

  // One body: mostly name=value fields built around the key, sometimes raw noise
  task automatic append_body();
    int ke;
    int nfields;
    int kind;
    ke = eff_key_len();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(1, 255)));
    end else begin
      nfields = $urandom_range(1, 3);
      for (int f = 0; f < nfields; f++) begin
        if (f != 0) begin
          push_byte(CH_AMP);
        end
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
          for (int i = 0; i < ke; i++) push_byte(key_cfg[8*i +: 8]);
        end else if (kind == 5) begin
          for (int i = 0; i < ke - 1; i++) push_byte(key_cfg[8*i +: 8]);
        end else if (kind == 6) begin
          for (int i = 0; i < ke; i++) push_byte(key_cfg[8*i +: 8]);
          push_byte(name_char());
        end else begin
          repeat ($urandom_range(0, 3)) push_byte(name_char());
        end
        if ($urandom_range(0, 9) != 0) begin
          push_byte(CH_EQUAL);
        end
        repeat ($urandom_range(0, 8)) push_value_piece();
      end
      // leave an escape open at end of body now and then
      case ($urandom_range(0, 11))
        0: push_byte(CH_PERCENT);
        1: begin
          push_byte(CH_PERCENT);
          push_byte(hex_char());
        end
        default: ;
      endcase
    end
    push_byte(CH_EOB);
  endtask

  // Register writes go out on consecutive edges; the copy follows the same order
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_KEY_LENGTH:     key_len_cfg = val[4:0];
      CFG_KEY_BYTES_LOW:  key_cfg[63:0] = val;
      CFG_KEY_BYTES_HIGH: key_cfg[127:64] = val;
      CFG_VALUE_CAPACITY: cap_cfg = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [63:0] klen, input logic [63:0] lo,
                            input logic [63:0] hi, input logic [63:0] cap);
    write_reg(CFG_KEY_LENGTH, klen);
    write_reg(CFG_KEY_BYTES_LOW, lo);
    write_reg(CFG_KEY_BYTES_HIGH, hi);
    write_reg(CFG_VALUE_CAPACITY, cap);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Hold until every byte is taken and every word has come back; look between
  // edges so a byte popped on the last edge already shows on in_tvalid
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (body_q.size() != 0 || in_tvalid || expect_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    error_count++;
    $display("MISMATCH at word %0d: %s expected 0x%0h got 0x%0h", words_seen, what,
             want, got);
  endtask

  // ------------------------------------------------------------------
  // Driver: offer the next body byte; predict on acceptance
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'd0;
      send_wait = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_body_byte(in_tdata);
      end
      // advance only when the slot is free; hold the word while stalled
      if (!in_tvalid || in_tready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_tvalid <= 1'b0;
        end else if (body_q.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= body_q.pop_front();
          send_wait = draw_gap(send_mode);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Monitor: check each result word against the oldest expectation
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        words_seen++;
        if (expect_q.size() == 0) begin
          report_mismatch("word with nothing pending, tdata", 0, out_tdata);
        end else begin
          want_word = expect_q.pop_front();
          if (out_tdata[7:0] !== want_word.value_byte)
            report_mismatch("value_byte", want_word.value_byte, out_tdata[7:0]);
          if (out_tuser !== want_word.is_char)
            report_mismatch("is_char", want_word.is_char, out_tuser);
          if (out_tdata[8] !== want_word.found)
            report_mismatch("found", want_word.found, out_tdata[8]);
          if (out_tdata[16:9] !== want_word.value_length)
            report_mismatch("value_length", want_word.value_length, out_tdata[16:9]);
          if (out_tlast !== want_word.last)
            report_mismatch("last", want_word.last, out_tlast);
        end
        recv_wait = draw_gap(recv_mode);
      end
      // the long hold-off overrides the per-word idle count
      if (hold_off) begin
        out_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off: the sender keeps offering, so the result queue
  // fills and the core has to drop in_tready
  initial begin
    wait (stall_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Sequence: reset, directed bodies, then random phases over many settings
  // ------------------------------------------------------------------
  initial begin
    logic [63:0] klen;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] cap;

    key_len_cfg = 5'd4;
    key_cfg     = '0;
    cap_cfg     = 8'd64;
    clear_scan();

    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Key "id": plus, escapes, broken escapes, end of body with a held '%'
    // and with a held '%' plus digit, a decoded zero byte, a top-bit byte
    send_mode = 1;
    recv_mode = 1;
    set_config(64'd2, 64'h6469, 64'd0, 64'd255);
    push_text("id=+%4a%%z%");
    push_byte(CH_EOB);
    push_text("q&id=%7");
    push_byte(CH_EOB);
    push_text("id=%00");
    push_byte(8'hFF);
    push_byte(CH_EOB);
    wait_drained();

    // Zero capacity: the key never matches
    set_config(64'd1, 64'h61, 64'd0, 64'd0);
    push_text("a=x");
    push_byte(CH_EOB);
    wait_drained();

    // Capacity 2: one value byte, then the value is cut off
    set_config(64'd1, 64'h61, 64'd0, 64'd2);
    push_text("a=xyz");
    push_byte(CH_EOB);
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      lo = alphabet_key();
      hi = alphabet_key();
      case (p)
        0: begin klen = 3;  cap = 255; end
        1: begin klen = 16; cap = 20;  end
        2: begin klen = 31; cap = 255; lo = '1; hi = '1; end
        3: begin klen = 0;  cap = 1;   end
        4: begin klen = 2;  cap = 6;   end
        5: begin
          klen = $urandom_range(0, 31);
          cap  = $urandom_range(0, 255);
          lo   = {$urandom, $urandom};
          hi   = {$urandom, $urandom};
        end
        6: begin klen = 5;  cap = 0;   lo = '0; hi = '0; end
        7: begin klen = 3;  cap = 2;   end
        default: begin
          klen = $urandom_range(1, 6);
          cap  = ($urandom_range(0, 1) == 0) ? 64 : $urandom_range(2, 10);
        end
      endcase
      set_config(klen, lo, hi, cap);
      // phase 4 runs flat out on both sides so the hold-off backs up the core
      send_mode = (p == 4) ? 0 : p % 3;
      recv_mode = (p == 4) ? 0 : (p + 1) % 3;
      bytes_queued = 0;
      while (bytes_queued < PHASE_BYTES) begin
        append_body();
      end
      if (p == 4) begin
        stall_go = 1'b1;
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (error_count == 0 && expect_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
